@@ design/crl_pkg.sv @@
// Package for the challenge replay ledger: sizes, codes, word and state types.
// No dependencies.
`timescale 1ns / 1ps
package crl_pkg;
   localparam int MAX_ENTRIES = 64;
   localparam int MAX_CHALLENGE_BYTES = 128;
   localparam int KEY_WORDS = (MAX_CHALLENGE_BYTES + 7) / 8;
   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int WORD_W = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
   localparam int LEN_W = $clog2(MAX_CHALLENGE_BYTES + 2);
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int KADDR_W = (MAX_ENTRIES * KEY_WORDS > 1) ?
                            $clog2(MAX_ENTRIES * KEY_WORDS) : 1;

   localparam logic [1:0] CMD_RESERVE  = 2'd0;
   localparam logic [1:0] CMD_COMMIT   = 2'd1;
   localparam logic [1:0] CMD_ROLLBACK = 2'd2;
   localparam logic [1:0] CMD_FORGET   = 2'd3;

   localparam logic [2:0] ST_RESERVED = 3'd0;
   localparam logic [2:0] ST_PENDING  = 3'd1;
   localparam logic [2:0] ST_SPENT    = 3'd2;
   localparam logic [2:0] ST_REJECTED = 3'd3;
   localparam logic [2:0] ST_DONE     = 3'd4;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [63:0] generation;
      logic [63:0] chunk;
      logic [3:0]  chunk_bytes;
      logic        last_chunk;
      logic [63:0] expires_at;
      logic [63:0] now_time;
   } req_word_type;

   typedef struct packed {
      logic [2:0] status;
      logic [6:0] entry_count;
   } rsp_word_type;

   typedef struct packed {
      logic [63:0]      generation;
      logic [63:0]      expiry;
      logic [LEN_W-1:0] length;
   } meta_type;

   typedef enum logic [3:0] {
      S_IDLE, S_CHECK, S_PRUNE, S_SWEEP, S_FIND, S_KEY, S_HIT, S_MISS, S_FILL, S_RESP
   } state_type;
endpackage

@@ design/challenge_replay_ledger_unit.sv @@
// Challenge replay ledger top: command sequencer over entry metadata and key RAMs.
// Depends on crl_pkg, crl_ram, crl_inbuf.
//
// Usage: a request word carries one challenge chunk; chunks are packed into an
// internal buffer. The word with last_chunk set runs the command and gives one
// response word (status, live entry count); other words give none.
// A non-final chunk is taken while idle. A command walks the entry table one entry
// per cycle through the metadata RAM, and a candidate whose generation and
// length match is compared one key word per cycle through the key RAM:
//   commit/rollback: entry walk, key compares, hit or miss step, response
//   forget:          sweep of every entry, response
//   reserve:         check, prune of every entry, find as above, key fill on a miss
// A reserve that fails the check goes straight to the response; the table walk
// and the key compares set how long a command runs.
// req_stall is high while a command runs. The response sits in an output
// register; while rsp_stall holds it, new chunks are still taken, and the next
// command waits at its end until the register frees.
// Reset (synchronous) empties the table and the chunk buffer at once.
`timescale 1ns / 1ps
module challenge_replay_ledger_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  crl_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output crl_pkg::rsp_word_type rsp_word
);
   import crl_pkg::*;

   state_type         state_ff, state_in;
   logic [1:0]        cmd_ff, cmd_in;
   logic [63:0]       gen_ff, gen_in, exp_ff, exp_in, now_ff, now_in;
   logic [IDX_W-1:0]  idx_ff, idx_in, free_ff, free_in;
   logic              free_found_ff, free_found_in;
   logic [WORD_W-1:0] w_ff, w_in;
   logic [MAX_ENTRIES-1:0] valid_ff, valid_in, committed_ff, committed_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [2:0]        status_ff, status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_word_type      rsp_word_ff, rsp_word_in;

   meta_type          meta_rd, meta_wr;
   logic              meta_we;
   logic [63:0]       key_rd, inc_word;
   logic              key_we;
   logic [KADDR_W-1:0] key_waddr, key_raddr;
   logic [LEN_W-1:0]  inc_len;
   logic [WORD_W:0]   nw;
   logic              accept, absorb, clear, last_idx, meta_match, out_free;

   assign accept   = req_valid && !req_stall;
   assign absorb   = accept;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign last_idx = idx_ff == IDX_W'(MAX_ENTRIES - 1);
   assign nw       = (WORD_W + 1)'(({1'b0, inc_len} + (LEN_W + 1)'(7)) >> 3);
   assign meta_match = valid_ff[idx_ff] && meta_rd.generation == gen_ff &&
                       meta_rd.length == inc_len;
   assign meta_wr  = '{generation: gen_ff, expiry: exp_ff, length: inc_len};
   assign key_waddr = KADDR_W'(free_ff * KEY_WORDS + w_ff);
   assign key_raddr = KADDR_W'(idx_in * KEY_WORDS + w_in);

   crl_inbuf u_inbuf (
      .clock(clock), .reset(reset), .absorb(absorb), .clear(clear),
      .chunk(req_word.chunk), .chunk_bytes(req_word.chunk_bytes),
      .rd_index(w_ff), .rd_word(inc_word), .length(inc_len)
   );

   crl_ram #(.WIDTH($bits(meta_type)), .DEPTH(MAX_ENTRIES)) u_meta_ram (
      .clock(clock), .wr_en(meta_we), .wr_addr(free_ff), .wr_data(meta_wr),
      .rd_addr(idx_in), .rd_data(meta_rd)
   );

   crl_ram #(.WIDTH(64), .DEPTH(MAX_ENTRIES * KEY_WORDS)) u_key_ram (
      .clock(clock), .wr_en(key_we), .wr_addr(key_waddr), .wr_data(inc_word),
      .rd_addr(key_raddr), .rd_data(key_rd)
   );

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      gen_in        = gen_ff;
      exp_in        = exp_ff;
      now_in        = now_ff;
      idx_in        = idx_ff;
      free_in       = free_ff;
      free_found_in = free_found_ff;
      w_in          = w_ff;
      valid_in      = valid_ff;
      committed_in  = committed_ff;
      count_in      = count_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_word_in   = rsp_word_ff;
      meta_we       = 1'b0;
      key_we        = 1'b0;
      clear         = 1'b0;
      req_stall     = state_ff != S_IDLE;
      case (state_ff)
         S_IDLE: begin
            if (accept && req_word.last_chunk) begin
               cmd_in        = req_word.cmd;
               gen_in        = req_word.generation;
               exp_in        = req_word.expires_at;
               now_in        = req_word.now_time;
               idx_in        = '0;
               w_in          = '0;
               free_found_in = 1'b0;
               case (req_word.cmd)
                  CMD_RESERVE: state_in = S_CHECK;
                  CMD_FORGET:  state_in = S_SWEEP;
                  default:     state_in = S_FIND;
               endcase
            end
         end
         S_CHECK: begin
            if (gen_ff == '0 || inc_len == '0 ||
                inc_len > LEN_W'(MAX_CHALLENGE_BYTES) || exp_ff == '0 ||
                now_ff == '0 || now_ff >= exp_ff) begin
               status_in = ST_REJECTED;
               state_in  = S_RESP;
            end else begin
               state_in = S_PRUNE;
            end
         end
         S_PRUNE: begin
            if (valid_ff[idx_ff] && now_ff >= meta_rd.expiry) begin
               valid_in[idx_ff]     = 1'b0;
               committed_in[idx_ff] = 1'b0;
               count_in             = count_ff - 1'b1;
            end
            if (last_idx) begin
               idx_in   = '0;
               state_in = S_FIND;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_SWEEP: begin
            if (valid_ff[idx_ff] && meta_rd.generation == gen_ff) begin
               valid_in[idx_ff]     = 1'b0;
               committed_in[idx_ff] = 1'b0;
               count_in             = count_ff - 1'b1;
            end
            if (last_idx) begin
               status_in = ST_DONE;
               state_in  = S_RESP;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_FIND: begin
            if (!valid_ff[idx_ff] && !free_found_ff) begin
               free_in       = idx_ff;
               free_found_in = 1'b1;
            end
            if (meta_match) begin
               w_in     = '0;
               state_in = S_KEY;
            end else if (last_idx) begin
               state_in = S_MISS;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_KEY: begin
            if (key_rd != inc_word) begin
               w_in = '0;
               if (last_idx) begin
                  state_in = S_MISS;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_FIND;
               end
            end else if ({1'b0, w_ff} == nw - 1'b1) begin
               state_in = S_HIT;
            end else begin
               w_in = w_ff + 1'b1;
            end
         end
         S_HIT: begin
            status_in = ST_DONE;
            case (cmd_ff)
               CMD_RESERVE: status_in = committed_ff[idx_ff] ? ST_SPENT : ST_PENDING;
               CMD_COMMIT:  committed_in[idx_ff] = 1'b1;
               CMD_ROLLBACK: begin
                  if (!committed_ff[idx_ff]) begin
                     valid_in[idx_ff] = 1'b0;
                     count_in         = count_ff - 1'b1;
                  end
               end
               default: status_in = ST_DONE;
            endcase
            state_in = S_RESP;
         end
         S_MISS: begin
            status_in = ST_DONE;
            state_in  = S_RESP;
            if (cmd_ff == CMD_RESERVE) begin
               if (free_found_ff) begin
                  meta_we               = 1'b1;
                  valid_in[free_ff]     = 1'b1;
                  committed_in[free_ff] = 1'b0;
                  count_in              = count_ff + 1'b1;
                  w_in                  = '0;
                  state_in              = S_FILL;
               end else begin
                  status_in = ST_REJECTED;
               end
            end
         end
         S_FILL: begin
            key_we = 1'b1;
            if ({1'b0, w_ff} == nw - 1'b1) begin
               status_in = ST_RESERVED;
               state_in  = S_RESP;
            end else begin
               w_in = w_ff + 1'b1;
            end
         end
         S_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = '{status: status_ff, entry_count: 7'(count_ff)};
               clear        = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         valid_ff      <= '0;
         committed_ff  <= '0;
         count_ff      <= '0;
         free_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         committed_ff  <= committed_in;
         count_ff      <= count_in;
         free_found_ff <= free_found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      gen_ff      <= gen_in;
      exp_ff      <= exp_in;
      now_ff      <= now_in;
      idx_ff      <= idx_in;
      free_ff     <= free_in;
      w_ff        <= w_in;
      status_ff   <= status_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      count_ff == CNT_W'($countones(valid_ff)))
      else $error("entry count out of step with valid bits");
   a_committed_live: assert property (@(posedge clock) disable iff (reset)
      (committed_ff & ~valid_ff) == '0)
      else $error("committed mark on a free entry");
   a_fill_has_slot: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FILL |-> free_found_ff && valid_ff[free_ff])
      else $error("key fill without a claimed slot");
   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      accept && req_word.last_chunk |=> req_stall)
      else $error("final chunk did not start a command");
endmodule

@@ design/crl_ram.sv @@
// Generic simple dual port RAM, one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module crl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ design/crl_inbuf.sv @@
// Incoming challenge buffer: packs chunk bytes into key words, saturating length.
// Depends on crl_pkg.
`timescale 1ns / 1ps
module crl_inbuf (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       absorb,
   input  logic                       clear,
   input  logic [63:0]                chunk,
   input  logic [3:0]                 chunk_bytes,
   input  logic [crl_pkg::WORD_W-1:0] rd_index,
   output logic [63:0]                rd_word,
   output logic [crl_pkg::LEN_W-1:0]  length
);
   import crl_pkg::*;

   logic [63:0]       words_ff [KEY_WORDS];
   logic [63:0]       words_in [KEY_WORDS];
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [3:0]        nbytes;
   logic [WORD_W-1:0] widx;
   logic [2:0]        bofs;

   always_comb begin
      words_in = words_ff;
      len_in   = len_ff;
      nbytes   = (chunk_bytes > 4'd8) ? 4'd8 : chunk_bytes;
      widx     = '0;
      bofs     = '0;
      if (clear) begin
         for (int i = 0; i < KEY_WORDS; i++) words_in[i] = '0;
         len_in = '0;
      end else if (absorb) begin
         for (int b = 0; b < 8; b++) begin
            if (4'(b) < nbytes) begin
               if (len_in < LEN_W'(MAX_CHALLENGE_BYTES)) begin
                  widx = WORD_W'(len_in >> 3);
                  bofs = len_in[2:0];
                  words_in[widx][{bofs, 3'b000} +: 8] = chunk[8*b +: 8];
                  len_in = len_in + 1'b1;
               end else begin
                  len_in = LEN_W'(MAX_CHALLENGE_BYTES + 1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         for (int i = 0; i < KEY_WORDS; i++) words_ff[i] <= '0;
      end else begin
         len_ff   <= len_in;
         words_ff <= words_in;
      end
   end

   assign rd_word = words_ff[rd_index];
   assign length  = len_ff;
endmodule
